[rtl/assert_macros.svh]
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPLY(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error("assertion failed: ante |-> cons");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
    else $error("assertion failed: ante |=> cons");

`else

`define ASSERT_IMPLY(lbl, clk_s, rstn_s, ante, cons)
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons)

`endif

`endif

[rtl/wsfu_pkg.sv]
// Types and constants of the WebSocket frame unmasker.
`timescale 1ns / 1ps

package wsfu_pkg;

  localparam logic [2:0] ST_PAYLOAD   = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_UNMASKED  = 3'd2;
  localparam logic [2:0] ST_LEN64     = 3'd3;
  localparam logic [2:0] ST_TRUNCATED = 3'd4;

  localparam logic [7:0] FIN_BIT       = 8'h80;
  localparam logic [7:0] MASK_BIT      = 8'h80;
  localparam logic [7:0] OPCODE_MASK   = 8'h0F;
  localparam logic [7:0] LEN7_MASK     = 8'h7F;
  localparam logic [6:0] LEN_CODE_EXT  = 7'd126;
  localparam logic [6:0] LEN_CODE_64   = 7'd127;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last;
    logic [3:0] opcode;
    logic       final_fragment;
    logic [2:0] status;
  } out_t;

endpackage

[rtl/websocket_frame_unmasker.sv]
// Top level of the WebSocket client frame deframer and unmasker.
// Input channel in_valid/in_stall/in_data carries one raw stream byte per
// transaction, with frame_start set on the first header byte of each frame.
// Output channel out_valid/out_stall/out_data carries at most one result per
// input byte: an unmasked payload byte (status 0, last on the final byte), an
// empty-frame marker, or an error (unmasked, 64-bit length, truncated frame).
// Header, length and key bytes give no result but an error or, for the last
// key byte of a frame with no payload, the empty-frame marker. Throughput:
// one byte per cycle while the receiver does not stall; an input register and
// a result register bound the parse and unmask logic, in that order.
// When the receiver stalls with a result held, the input register holds its
// byte and in_stall rises; input moves again the cycle the result is taken.
// Reset (rst_n low, synchronous) empties both registers and returns the
// parser to waiting for a frame start; the masking key is not cleared, since
// every frame writes all four key bytes before any payload byte reads them.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module websocket_frame_unmasker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  wsfu_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output wsfu_pkg::out_t out_data
);
  import wsfu_pkg::*;

  typedef enum logic [6:0] {
    PH_IDLE    = 7'b0000001,
    PH_LEN     = 7'b0000010,
    PH_EXT_HI  = 7'b0000100,
    PH_EXT_LO  = 7'b0001000,
    PH_KEY     = 7'b0010000,
    PH_PAYLOAD = 7'b0100000,
    PH_DROP    = 7'b1000000
  } phase_t;

  logic        s1_valid_r;
  in_t         s1_data_r;
  logic        s1_go;
  logic        s1_fire;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  opcode_r, opcode_nxt;
  logic        fin_r, fin_nxt;
  logic [15:0] remaining_r, remaining_nxt;
  logic [7:0]  len_hi_r, len_hi_nxt;
  logic [1:0]  key_pos_r, key_pos_nxt;
  logic [7:0]  mask_key_r [4];
  logic        key_we;

  logic        res_valid;
  out_t        res_data;
  logic        out_valid_r;
  out_t        out_data_r;

  logic [7:0]  b;
  logic        start;

  assign s1_go    = !(out_valid_r && out_stall);
  assign s1_fire  = s1_valid_r && s1_go;
  assign in_stall = s1_valid_r && !s1_go;
  assign b        = s1_data_r.data_byte;
  assign start    = s1_data_r.frame_start;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
    if (!in_stall && in_valid) begin
      s1_data_r <= in_data;
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    opcode_nxt    = opcode_r;
    fin_nxt       = fin_r;
    remaining_nxt = remaining_r;
    len_hi_nxt    = len_hi_r;
    key_pos_nxt   = key_pos_r;
    key_we        = 1'b0;
    res_valid     = 1'b0;
    res_data.payload_byte   = 8'h00;
    res_data.last           = 1'b1;
    res_data.opcode         = opcode_r;
    res_data.final_fragment = fin_r;
    res_data.status         = ST_PAYLOAD;

    if (start) begin
      if (phase_r != PH_IDLE && phase_r != PH_DROP) begin
        res_valid       = 1'b1;
        res_data.status = ST_TRUNCATED;
      end
      opcode_nxt = b[3:0] & OPCODE_MASK[3:0];
      fin_nxt    = (b & FIN_BIT) != 8'h00;
      phase_nxt  = PH_LEN;
    end else begin
      unique case (phase_r)
        PH_LEN: begin
          if ((b & MASK_BIT) == 8'h00) begin
            phase_nxt       = PH_DROP;
            res_valid       = 1'b1;
            res_data.status = ST_UNMASKED;
          end else if (b[6:0] == LEN_CODE_64) begin
            phase_nxt       = PH_DROP;
            res_valid       = 1'b1;
            res_data.status = ST_LEN64;
          end else if (b[6:0] == LEN_CODE_EXT) begin
            phase_nxt = PH_EXT_HI;
          end else begin
            remaining_nxt = {8'h00, b & LEN7_MASK};
            key_pos_nxt   = 2'd0;
            phase_nxt     = PH_KEY;
          end
        end
        PH_EXT_HI: begin
          len_hi_nxt = b;
          phase_nxt  = PH_EXT_LO;
        end
        PH_EXT_LO: begin
          remaining_nxt = {len_hi_r, b};
          key_pos_nxt   = 2'd0;
          phase_nxt     = PH_KEY;
        end
        PH_KEY: begin
          key_we      = 1'b1;
          key_pos_nxt = key_pos_r + 2'd1;
          if (key_pos_r == 2'd3) begin
            if (remaining_r == 16'd0) begin
              phase_nxt       = PH_IDLE;
              res_valid       = 1'b1;
              res_data.status = ST_EMPTY;
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          key_pos_nxt   = key_pos_r + 2'd1;
          remaining_nxt = remaining_r - 16'd1;
          res_valid     = 1'b1;
          res_data.payload_byte = b ^ mask_key_r[key_pos_r];
          res_data.last         = (remaining_r == 16'd1);
          if (remaining_r == 16'd1) begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_IDLE, PH_DROP: begin
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      opcode_r    <= 4'd0;
      fin_r       <= 1'b0;
      remaining_r <= 16'd0;
      len_hi_r    <= 8'd0;
      key_pos_r   <= 2'd0;
    end else if (s1_fire) begin
      phase_r     <= phase_nxt;
      opcode_r    <= opcode_nxt;
      fin_r       <= fin_nxt;
      remaining_r <= remaining_nxt;
      len_hi_r    <= len_hi_nxt;
      key_pos_r   <= key_pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && key_we && !start) begin
      mask_key_r[key_pos_r] <= b;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= s1_fire && res_valid;
    end
    if (s1_fire && res_valid) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_IMPLY(a_err_is_last, clk, rst_n, out_valid_r && out_data_r.status != ST_PAYLOAD, out_data_r.last && out_data_r.payload_byte == 8'h00)
  `ASSERT_IMPLY(a_payload_count, clk, rst_n, phase_r == PH_PAYLOAD, remaining_r != 16'd0)
  `ASSERT_NEXT(a_truncate, clk, rst_n, s1_fire && start && phase_r != PH_IDLE && phase_r != PH_DROP, out_valid_r && out_data_r.status == ST_TRUNCATED)

endmodule
